@@ src/cle_pkg.sv @@
// Package for the console line editor: widths, reset values, character codes,
// result kinds and the command/status types between controller and datapath.
// No dependencies.
package cle_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    localparam int BYTE_W    = 8;
    localparam int CAP_W     = 6;
    localparam int TIMEOUT_W = 24;
    localparam int TIME_W    = 25;
    localparam int KIND_W    = 2;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CAP_W-1:0]     CAP_RESET  = 6'd32;
    localparam logic [TIMEOUT_W-1:0] IDLE_RESET = 24'd1000000;
    localparam logic [TIMEOUT_W-1:0] GAP_RESET  = 24'd1500000;
    localparam logic [TIME_W-1:0]    TIME_MAX   = {TIME_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DEL = 8'h7f;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    // What an accepted item will produce.
    typedef enum logic [2:0] {
        CL_NONE,
        CL_EMPTY,
        CL_DUMP,
        CL_EOL,
        CL_BS,
        CL_CHAR,
        CL_CHAR_DUMP
    } t_item_class;

    // Which result the output register is loaded with.
    typedef enum logic [2:0] {
        SEL_EMPTY,
        SEL_CR,
        SEL_LF,
        SEL_BS,
        SEL_SP,
        SEL_ECHO,
        SEL_LINE
    } t_out_sel;

    typedef struct packed {
        logic     take;
        logic     load;
        t_out_sel sel;
        logic     last;
    } t_dp_cmd;

    typedef struct packed {
        t_item_class cls;
        logic        out_free;
        logic        dump_last;
    } t_dp_status;

endpackage

@@ src/cle_if.sv @@
// Channel interfaces of the console line editor: input items, result items
// and configuration writes. Depends on cle_pkg.
interface cle_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [cle_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface cle_out_if;
    logic                       valid;
    logic                       ready;
    logic [cle_pkg::KIND_W-1:0] out_kind;
    logic [cle_pkg::BYTE_W-1:0] out_byte;
    logic [cle_pkg::LEN_W-1:0]  line_length;
    logic                       last;

    modport source (output valid, output out_kind, output out_byte, output line_length,
                    output last, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input line_length,
                    input last, output ready);
endinterface

interface cle_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cle_pkg::CFG_IDX_W-1:0] index;
    logic [cle_pkg::TIMEOUT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/console_line_editor_top.sv @@
// Top level of the console line editor: controller plus datapath behind
// valid/ready channels. Depends on cle_pkg, cle_if, cle_ctrl, cle_datapath.
//
//   channel   direction  payload                                  accepted when
//   i_in      in         cmd, rx_byte                             valid && ready
//   o_out     out        out_kind, out_byte, line_length, last    valid && ready
//   i_cfg     in         index, data                              valid && ready
//
// Results of an item leave one per cycle through the output register unless
// the output stalls: a tick or a backspace on an empty line gives none, a
// timeout one empty result, an echo its byte or backspace, space, backspace,
// and a completed line its echo and its L bytes, each read from the line store.
// Input is taken only between items; output stalls hold the sequencer.
// Reset is synchronous and active low; no clearing pass is needed.
module console_line_editor_top #(
    parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cle_in_if.sink           i_in,
    cle_out_if.source        o_out,
    cle_cfg_if.sink          i_cfg
);

    cle_pkg::t_dp_cmd    w_cmd;
    cle_pkg::t_dp_status w_status;
    logic                w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cle_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_in_cmd      (i_in.cmd),
        .i_in_byte     (i_in.rx_byte),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_kind    (o_out.out_kind),
        .o_out_byte    (o_out.out_byte),
        .o_line_length (o_out.line_length),
        .o_out_last    (o_out.last)
    );

endmodule

@@ src/cle_datapath.sv @@
// Datapath of the console line editor: configuration registers, line store,
// fill count, tick counters, dump index and the output register.
// Depends on cle_pkg.
module cle_datapath #(
    parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cle_pkg::t_dp_cmd              i_cmd,
    output cle_pkg::t_dp_status           o_status,
    input  logic                          i_in_cmd,
    input  logic [cle_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic                          i_cfg_valid,
    input  logic [cle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cle_pkg::TIMEOUT_W-1:0] i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [cle_pkg::KIND_W-1:0]    o_out_kind,
    output logic [cle_pkg::BYTE_W-1:0]    o_out_byte,
    output logic [cle_pkg::LEN_W-1:0]     o_line_length,
    output logic                          o_out_last
);

    localparam int FW = $clog2(LINE_DEPTH);
    localparam int CW = cle_pkg::CAP_W;
    localparam int TW = cle_pkg::TIME_W;
    localparam int LW = cle_pkg::LEN_W;
    localparam int BW = cle_pkg::BYTE_W;

    logic [CW-1:0]                  r_cap;
    logic [cle_pkg::TIMEOUT_W-1:0]  r_idle;
    logic [cle_pkg::TIMEOUT_W-1:0]  r_gap;

    logic [BW-1:0]                  r_mem [LINE_DEPTH];
    logic [BW-1:0]                  r_rd_data;
    logic [FW-1:0]                  r_fill, n_fill;
    logic [FW-1:0]                  r_idx, n_idx;
    logic [TW-1:0]                  r_since_start, n_since_start;
    logic [TW-1:0]                  r_since_last, n_since_last;
    logic [BW-1:0]                  r_echo;

    logic                           r_out_valid;
    logic [cle_pkg::KIND_W-1:0]     r_out_kind;
    logic [BW-1:0]                  r_out_byte;
    logic [LW-1:0]                  r_out_len;
    logic                           r_out_last;

    logic [CW-1:0]                  eff_cap;
    logic [CW-1:0]                  limit;
    logic [CW-1:0]                  fill_ext;
    logic [TW-1:0]                  start_inc;
    logic [TW-1:0]                  last_inc;
    logic                           timeout;
    logic                           is_eol;
    logic                           is_bs;
    logic                           dump_last;
    logic                           dump_end;
    logic                           mem_we;
    logic [BW-1:0]                  mem_wdata;
    cle_pkg::t_item_class           cls;

    // Capacity outside 2..LINE_DEPTH is clamped into range.
    assign eff_cap = (r_cap < CW'(2)) ? CW'(2) :
                     (r_cap > CW'(LINE_DEPTH)) ? CW'(LINE_DEPTH) : r_cap;
    assign limit    = eff_cap - CW'(1);
    assign fill_ext = CW'(r_fill);

    assign start_inc = (r_since_start == cle_pkg::TIME_MAX) ? r_since_start
                                                             : r_since_start + TW'(1);
    assign last_inc  = (r_since_last == cle_pkg::TIME_MAX) ? r_since_last
                                                            : r_since_last + TW'(1);

    assign timeout = ((r_fill == '0) && (start_inc > TW'(r_idle))) ||
                     ((r_fill != '0) && (last_inc > TW'(r_gap)));

    assign is_eol = (i_in_byte == cle_pkg::CH_CR) || (i_in_byte == cle_pkg::CH_LF);
    assign is_bs  = (i_in_byte == cle_pkg::CH_BS) || (i_in_byte == cle_pkg::CH_DEL);

    always_comb begin
        if (i_in_cmd == cle_pkg::CMD_TICK) begin
            cls = timeout ? cle_pkg::CL_EMPTY : cle_pkg::CL_NONE;
        end else if (fill_ext >= limit) begin
            cls = cle_pkg::CL_DUMP;
        end else if (is_eol) begin
            cls = cle_pkg::CL_EOL;
        end else if (is_bs) begin
            cls = (r_fill != '0) ? cle_pkg::CL_BS : cle_pkg::CL_NONE;
        end else if ((fill_ext + CW'(1)) >= limit) begin
            cls = cle_pkg::CL_CHAR_DUMP;
        end else begin
            cls = cle_pkg::CL_CHAR;
        end
    end

    assign dump_last = ((r_idx + FW'(1)) == r_fill);
    assign dump_end  = i_cmd.load && (i_cmd.sel == cle_pkg::SEL_LINE) && dump_last;

    assign o_status.cls       = cls;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.dump_last = dump_last;

    assign mem_we    = i_cmd.take && ((cls == cle_pkg::CL_EOL) || (cls == cle_pkg::CL_CHAR) ||
                                      (cls == cle_pkg::CL_CHAR_DUMP));
    assign mem_wdata = (cls == cle_pkg::CL_EOL) ? cle_pkg::CH_LF : i_in_byte;

    always_comb begin
        n_fill        = r_fill;
        n_since_start = r_since_start;
        n_since_last  = r_since_last;
        n_idx         = r_idx;
        if (i_cmd.take) begin
            n_idx = '0;
            if (i_in_cmd == cle_pkg::CMD_TICK) begin
                if (timeout) begin
                    n_fill        = '0;
                    n_since_start = '0;
                    n_since_last  = '0;
                end else begin
                    n_since_start = start_inc;
                    n_since_last  = last_inc;
                end
            end else begin
                n_since_last = '0;
                case (cls)
                    cle_pkg::CL_EOL,
                    cle_pkg::CL_CHAR,
                    cle_pkg::CL_CHAR_DUMP: n_fill = r_fill + FW'(1);
                    cle_pkg::CL_BS:        n_fill = r_fill - FW'(1);
                    default:               n_fill = r_fill;
                endcase
            end
        end else if (dump_end) begin
            n_fill        = '0;
            n_since_start = '0;
            n_since_last  = '0;
        end else if (i_cmd.load && (i_cmd.sel == cle_pkg::SEL_LINE)) begin
            n_idx = r_idx + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap         <= cle_pkg::CAP_RESET;
            r_idle        <= cle_pkg::IDLE_RESET;
            r_gap         <= cle_pkg::GAP_RESET;
            r_fill        <= '0;
            r_idx         <= '0;
            r_since_start <= '0;
            r_since_last  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cle_pkg::REG_LINE_CAPACITY: r_cap  <= i_cfg_data[CW-1:0];
                    cle_pkg::REG_IDLE_TIMEOUT:  r_idle <= i_cfg_data;
                    cle_pkg::REG_GAP_TIMEOUT:   r_gap  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_fill        <= n_fill;
            r_idx         <= n_idx;
            r_since_start <= n_since_start;
            r_since_last  <= n_since_last;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The read address follows the next dump index, so the registered read
    // data matches the current index.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill] <= mem_wdata;
        end
        r_rd_data <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_echo <= i_in_byte;
        end
        if (i_cmd.load) begin
            r_out_last <= i_cmd.last;
            case (i_cmd.sel)
                cle_pkg::SEL_EMPTY: begin
                    r_out_kind <= cle_pkg::KIND_EMPTY;
                    r_out_byte <= cle_pkg::CH_NUL;
                    r_out_len  <= '0;
                end
                cle_pkg::SEL_CR: begin
                    r_out_kind <= cle_pkg::KIND_ECHO;
                    r_out_byte <= cle_pkg::CH_CR;
                    r_out_len  <= '0;
                end
                cle_pkg::SEL_LF: begin
                    r_out_kind <= cle_pkg::KIND_ECHO;
                    r_out_byte <= cle_pkg::CH_LF;
                    r_out_len  <= '0;
                end
                cle_pkg::SEL_BS: begin
                    r_out_kind <= cle_pkg::KIND_ECHO;
                    r_out_byte <= cle_pkg::CH_BS;
                    r_out_len  <= '0;
                end
                cle_pkg::SEL_SP: begin
                    r_out_kind <= cle_pkg::KIND_ECHO;
                    r_out_byte <= cle_pkg::CH_SP;
                    r_out_len  <= '0;
                end
                cle_pkg::SEL_ECHO: begin
                    r_out_kind <= cle_pkg::KIND_ECHO;
                    r_out_byte <= r_echo;
                    r_out_len  <= '0;
                end
                cle_pkg::SEL_LINE: begin
                    r_out_kind <= cle_pkg::KIND_LINE;
                    r_out_byte <= r_rd_data;
                    r_out_len  <= LW'(r_fill);
                end
                default: begin
                    r_out_kind <= cle_pkg::KIND_EMPTY;
                    r_out_byte <= cle_pkg::CH_NUL;
                    r_out_len  <= '0;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_byte    = r_out_byte;
    assign o_line_length = r_out_len;
    assign o_out_last    = r_out_last;

endmodule

@@ src/cle_ctrl.sv @@
// Controller of the console line editor: accepts items and sequences the
// echo, line dump and timeout results into the datapath output register.
// Depends on cle_pkg.
module cle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cle_pkg::t_dp_status i_status,
    output cle_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMPTY,
        S_CR,
        S_LF,
        S_BS1,
        S_SP,
        S_BS2,
        S_ECHO,
        S_DUMP
    } t_state;

    t_state r_state, n_state;
    logic   r_dump_after, n_dump_after;
    logic   take;

    assign o_in_ready = (r_state == S_IDLE);
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_dump_after = r_dump_after;
        o_cmd.take   = take;
        o_cmd.load   = 1'b0;
        o_cmd.sel    = cle_pkg::SEL_EMPTY;
        o_cmd.last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_status.cls)
                        cle_pkg::CL_EMPTY: n_state = S_EMPTY;
                        cle_pkg::CL_DUMP:  n_state = S_DUMP;
                        cle_pkg::CL_EOL:   n_state = S_CR;
                        cle_pkg::CL_BS:    n_state = S_BS1;
                        cle_pkg::CL_CHAR: begin
                            n_state      = S_ECHO;
                            n_dump_after = 1'b0;
                        end
                        cle_pkg::CL_CHAR_DUMP: begin
                            n_state      = S_ECHO;
                            n_dump_after = 1'b1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EMPTY: begin
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = cle_pkg::SEL_EMPTY;
                o_cmd.last = 1'b1;
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_CR: begin
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = cle_pkg::SEL_CR;
                if (i_status.out_free) n_state = S_LF;
            end
            S_LF: begin
                // The stored terminator guarantees a non-empty dump follows.
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = cle_pkg::SEL_LF;
                if (i_status.out_free) n_state = S_DUMP;
            end
            S_BS1: begin
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = cle_pkg::SEL_BS;
                if (i_status.out_free) n_state = S_SP;
            end
            S_SP: begin
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = cle_pkg::SEL_SP;
                if (i_status.out_free) n_state = S_BS2;
            end
            S_BS2: begin
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = cle_pkg::SEL_BS;
                o_cmd.last = 1'b1;
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_ECHO: begin
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = cle_pkg::SEL_ECHO;
                o_cmd.last = !r_dump_after;
                if (i_status.out_free) n_state = r_dump_after ? S_DUMP : S_IDLE;
            end
            S_DUMP: begin
                o_cmd.load = i_status.out_free;
                o_cmd.sel  = cle_pkg::SEL_LINE;
                o_cmd.last = i_status.dump_last;
                if (i_status.out_free && i_status.dump_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dump_after <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dump_after <= n_dump_after;
        end
    end

endmodule
